[rtl/smis_pkg.sv]
// Package for the middle-insert set store.
// Holds the transaction structs, the operation and status codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package smis_pkg;

   // Operation codes carried in the kind field.
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // Status codes returned with every result.
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_DUP   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // Input transaction.
   typedef struct packed {
      logic        kind;
      logic [31:0] value;
   } smis_req_type;

   // Result transaction.
   typedef struct packed {
      logic [31:0] popped_value;
      logic [1:0]  status;
      logic [6:0]  entry_count;
   } smis_rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_POP_CAP,
      S_DN_RD,
      S_DN_WR,
      S_FINISH
   } smis_state_type;

endpackage

[rtl/middle_insert_set_store.sv]
// Top level of the middle-insert set store: handshakes and the result register.
// Instantiates smis_ctrl and smis_ram; depends on smis_pkg.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | smis_req_type {kind, value}
//  rsp     | out       | rsp_valid/rsp_stall  | smis_rsp_type {popped_value, status, entry_count}
//
// A push searches the held entries one at a time, then moves each entry above
// the middle position up, every move a read followed by a write through the
// store's single read and single write port. A pop reads the middle entry and
// moves each entry above it down the same way. Reset empties the set at once;
// the store is never cleared.
// A new transaction is taken once the sequencer is idle, even while a result
// still waits on rsp_stall.
`timescale 1ns / 1ps

module middle_insert_set_store #(
   parameter int CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  smis_pkg::smis_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smis_pkg::smis_rsp_type rsp_data
);

   import smis_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic          busy;
   logic          done;
   logic          req_accept;
   logic          out_free;
   smis_rsp_type  result;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   logic          rsp_valid_ff, rsp_valid_in;
   smis_rsp_type  rsp_data_ff, rsp_data_in;

   // Input handshake: one transaction at a time through the sequencer.
   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   smis_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .req_data (req_data),
      .out_free (out_free),
      .busy     (busy),
      .done     (done),
      .rsp_data (result),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   smis_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result register: loaded when the sequencer finishes, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A finished result never coincides with a newly accepted transaction.
   assert property (@(posedge clock) disable iff (reset) !(done && req_accept))
      else $error("result completed in the same cycle as a new transaction");

   // A finished result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
                    done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // A dropped push is reported only when the set is at capacity.
   assert property (@(posedge clock) disable iff (reset)
                    (done && result.status == ST_FULL) |->
                    (result.entry_count == 7'(CAPACITY) && result.popped_value == '0))
      else $error("full status reported with the set below capacity");

   // An empty pop reports an empty set and no word.
   assert property (@(posedge clock) disable iff (reset)
                    (done && result.status == ST_EMPTY) |->
                    (result.entry_count == '0 && result.popped_value == '0))
      else $error("empty status reported with entries held");

endmodule

[rtl/smis_ram.sv]
// Single-port-write, single-port-read store for the held words.
// Read data is registered; no dependencies.
`timescale 1ns / 1ps

module smis_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/smis_ctrl.sv]
// Sequencer for the middle-insert set store: search, shift and pop steps.
// Drives the word store through one read and one write address and owns the
// shared word comparator. Depends on smis_pkg.
`timescale 1ns / 1ps

module smis_ctrl #(
   parameter int CAPACITY = 64,
   parameter int AW       = 6,
   parameter int CW       = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  smis_pkg::smis_req_type req_data,
   input  logic                  out_free,
   output logic                  busy,
   output logic                  done,
   output smis_pkg::smis_rsp_type rsp_data,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  logic [31:0]           rd_data,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [31:0]           wr_data
);

   import smis_pkg::*;

   smis_state_type state_ff, state_in;

   logic [31:0]   word_ff, word_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   popped_ff, popped_in;

   logic [CW-1:0] push_pos;
   logic [CW-1:0] pop_pos;
   logic [CW-1:0] idx_inc;
   logic [CW-1:0] idx_dec;
   logic          full;
   logic          match;
   logic          more_search;

   // Positions, neighbours of the index and the shared comparator.
   always_comb begin
      push_pos    = count_ff >> 1;
      pop_pos     = (count_ff - CW'(1)) >> 1;
      idx_inc     = idx_ff + CW'(1);
      idx_dec     = idx_ff - CW'(1);
      full        = (count_ff == CW'(CAPACITY));
      match       = cmp_valid_ff && (rd_data == word_ff);
      more_search = (idx_ff < count_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.kind == KIND_PUSH) begin
                  state_in = S_SEARCH;
               end else if (count_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_POP_CAP;
               end
            end
         end
         S_SEARCH: begin
            priority if (match) begin
               state_in = S_FINISH;
            end else if (more_search) begin
               state_in = S_SEARCH;
            end else if (full) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            state_in = (idx_ff > push_pos) ? S_SHIFT_WR : S_PLACE;
         end
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_PLACE:    state_in = S_FINISH;
         S_POP_CAP:  state_in = S_DN_RD;
         S_DN_RD: begin
            state_in = (idx_inc < count_ff) ? S_DN_WR : S_FINISH;
         end
         S_DN_WR:    state_in = S_DN_RD;
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      word_in      = word_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmp_valid_in = 1'b0;
      status_in    = status_ff;
      popped_in    = popped_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data;
      done         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               word_in   = req_data.value;
               popped_in = '0;
               if (req_data.kind == KIND_PUSH) begin
                  idx_in = '0;
               end else if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  // The middle entry is read straight away.
                  rd_en   = 1'b1;
                  rd_addr = pop_pos[AW-1:0];
                  idx_in  = pop_pos;
               end
            end
         end
         S_SEARCH: begin
            // Reads are issued ahead of the comparison: each word is compared as the next read goes out.
            priority if (match) begin
               status_in = ST_DUP;
            end else if (more_search) begin
               rd_en        = 1'b1;
               rd_addr      = idx_ff[AW-1:0];
               idx_in       = idx_inc;
               cmp_valid_in = 1'b1;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               idx_in = count_ff;
            end
         end
         S_SHIFT_RD: begin
            // Fetch the entry below the free slot.
            if (idx_ff > push_pos) begin
               rd_en   = 1'b1;
               rd_addr = idx_dec[AW-1:0];
            end
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = idx_dec;
         end
         S_PLACE: begin
            wr_en     = 1'b1;
            wr_addr   = push_pos[AW-1:0];
            wr_data   = word_ff;
            count_in  = count_ff + CW'(1);
            status_in = ST_DONE;
         end
         S_POP_CAP: begin
            popped_in = rd_data;
         end
         S_DN_RD: begin
            // Fetch the entry above the gap, or finish the pop.
            if (idx_inc < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_inc[AW-1:0];
            end else begin
               count_in  = count_ff - CW'(1);
               status_in = ST_DONE;
            end
         end
         S_DN_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = idx_inc;
         end
         S_FINISH: begin
            done = out_free;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      rsp_data.popped_value = popped_ff;
      rsp_data.status       = status_ff;
      rsp_data.entry_count  = 7'(count_ff);
   end

endmodule
